### rtl/iat_pkg.sv
// Package for the indexed array table: sizes, action and status codes,
// sequencer states and the result record. No dependencies.
package iat_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 6;
   localparam int ENTRY_W  = 7;
   localparam int WORD_W   = 32;
   // compare width that holds both a position and a count
   localparam int EXT_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      ACT_PUSH   = 3'd0,
      ACT_POP    = 3'd1,
      ACT_GET    = 3'd2,
      ACT_INSERT = 3'd3,
      ACT_DELETE = 3'd4,
      ACT_SEARCH = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_EMPTY    = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_BADPOS   = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_INSERT,
      ST_DELETE,
      ST_SEARCH
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0]  read_value;
      logic [POS_W-1:0]   found_position;
      status_type         status;
      logic [ENTRY_W-1:0] entry_count;
   } rsp_type;

endpackage

### rtl/indexed_array_table_unit.sv
// Indexed array table: ordered table of 32-bit words in one synchronous RAM.
// Depends on iat_pkg.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   req_action selects push, pop, get, insert, delete or search, with
//   req_position and req_value as operands. Exactly one result follows,
//   shown for one cycle with rsp_strobe high; the receiver cannot stall it.
// Steps of each action, from acceptance to the result:
//   push, rejected actions, unused codes, search of an empty table: result registered on acceptance
//   pop, get: one RAM read, then the registered data is returned
//   insert at p with n entries: entries n-1 down to p each move up one slot, then the value is written at p
//   delete at p with n entries: entries p+1 up to n-1 each move down one slot, then the count drops
//   search with n entries: entries are read from 0 upward until a hit or the end of the table
// Insert, delete and search walk the RAM one entry per cycle through its
// single read port and single write port; start may be raised again in the
// cycle that carries the result.
// Reset clears the entry count and the sequencer; RAM contents are kept
// and only entries below the count are ever read.
module indexed_array_table_unit
   import iat_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_action,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [WORD_W-1:0]  req_value,
   output logic                      rsp_strobe,
   output logic signed [WORD_W-1:0]  rsp_read_value,
   output logic [POS_W-1:0]          rsp_found_position,
   output logic [2:0]                rsp_status,
   output logic [ENTRY_W-1:0]        rsp_entry_count
);

   logic [WORD_W-1:0] mem_array [CAPACITY];

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [WORD_W-1:0]  val_ff, val_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [WORD_W-1:0]  rdata_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [WORD_W-1:0]  mem_wdata;

   logic               accept;
   logic               is_full;
   logic               is_empty;
   logic [EXT_W-1:0]   pos_ext;
   logic [EXT_W-1:0]   cnt_ext;
   logic [CNT_W-1:0]   ptr_next_up;
   logic               ins_more;
   logic               del_more;
   logic               srch_hit;
   logic               srch_more;

   assign accept      = start && (state_ff == ST_IDLE);
   assign is_full     = (count_ff >= CNT_W'(CAPACITY));
   assign is_empty    = (count_ff == '0);
   assign pos_ext     = EXT_W'(req_position);
   assign cnt_ext     = EXT_W'(count_ff);
   assign ptr_next_up = ptr_ff + CNT_W'(1);
   assign ins_more    = (ptr_ff > pos_ff);
   assign del_more    = (ptr_next_up < count_ff);
   assign srch_hit    = pend_ff && (rdata_ff == val_ff);
   assign srch_more   = (ptr_ff < count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_POP: begin
                     if (!is_empty) state_in = ST_READ;
                  end
                  ACT_GET: begin
                     if (!is_empty && pos_ext < cnt_ext) state_in = ST_READ;
                  end
                  ACT_INSERT: begin
                     if (!is_full && pos_ext <= cnt_ext) state_in = ST_INSERT;
                  end
                  ACT_DELETE: begin
                     if (!is_empty && pos_ext < cnt_ext) state_in = ST_DELETE;
                  end
                  ACT_SEARCH: begin
                     if (!is_empty) state_in = ST_SEARCH;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:   state_in = ST_IDLE;
         ST_INSERT: begin
            if (!ins_more && !pend_ff) state_in = ST_IDLE;
         end
         ST_DELETE: begin
            if (!del_more && !pend_ff) state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            if (srch_hit || !srch_more) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      rsp_in       = rsp_ff;
      strobe_in    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff[ADDR_W-1:0];
      mem_wdata    = rdata_ff;
      mem_raddr    = ptr_ff[ADDR_W-1:0];
      rsp_in.read_value     = '0;
      rsp_in.found_position = '0;
      rsp_in.status         = STAT_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_in = 1'b0;
               unique case (req_action)
                  ACT_PUSH: begin
                     strobe_in = 1'b1;
                     if (is_full) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[ADDR_W-1:0];
                        mem_wdata = req_value;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_POP: begin
                     if (is_empty) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = STAT_EMPTY;
                     end else begin
                        count_in  = count_ff - CNT_W'(1);
                        mem_raddr = count_in[ADDR_W-1:0];
                     end
                  end
                  ACT_GET: begin
                     if (is_empty) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = STAT_EMPTY;
                     end else if (pos_ext >= cnt_ext) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = STAT_BADPOS;
                     end else begin
                        mem_raddr = pos_ext[ADDR_W-1:0];
                     end
                  end
                  ACT_INSERT: begin
                     if (is_full) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = STAT_FULL;
                     end else if (pos_ext > cnt_ext) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = STAT_BADPOS;
                     end else begin
                        ptr_in = count_ff;
                        pos_in = pos_ext[CNT_W-1:0];
                        val_in = req_value;
                     end
                  end
                  ACT_DELETE: begin
                     if (is_empty) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = STAT_EMPTY;
                     end else if (pos_ext >= cnt_ext) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = STAT_BADPOS;
                     end else begin
                        ptr_in = pos_ext[CNT_W-1:0];
                     end
                  end
                  ACT_SEARCH: begin
                     if (is_empty) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = STAT_NOTFOUND;
                     end else begin
                        ptr_in = '0;
                        val_in = req_value;
                     end
                  end
                  default: strobe_in = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            strobe_in         = 1'b1;
            rsp_in.read_value = rdata_ff;
         end
         ST_INSERT: begin
            // move entry ptr-1 up to ptr; each write comes in the cycle after its read
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = rdata_ff;
            end
            if (ins_more) begin
               ptr_in       = ptr_ff - CNT_W'(1);
               mem_raddr    = ptr_in[ADDR_W-1:0];
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff[ADDR_W-1:0];
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff[ADDR_W-1:0];
               mem_wdata = val_ff;
               count_in  = count_ff + CNT_W'(1);
               strobe_in = 1'b1;
            end
         end
         ST_DELETE: begin
            // move entry ptr+1 down to ptr
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = rdata_ff;
            end
            if (del_more) begin
               mem_raddr    = ptr_next_up[ADDR_W-1:0];
               ptr_in       = ptr_next_up;
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff[ADDR_W-1:0];
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               count_in  = count_ff - CNT_W'(1);
               strobe_in = 1'b1;
            end
         end
         ST_SEARCH: begin
            if (srch_hit) begin
               strobe_in             = 1'b1;
               rsp_in.found_position = POS_W'(pend_addr_ff);
            end else if (srch_more) begin
               mem_raddr    = ptr_ff[ADDR_W-1:0];
               ptr_in       = ptr_next_up;
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff[ADDR_W-1:0];
            end else begin
               strobe_in     = 1'b1;
               rsp_in.status = STAT_NOTFOUND;
            end
         end
         default: strobe_in = 1'b0;
      endcase

      if (!strobe_in) begin
         rsp_in = rsp_ff;
      end else begin
         rsp_in.entry_count = ENTRY_W'(count_in);
      end
   end

   // table RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem_array[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      pend_addr_ff <= pend_addr_in;
      rsp_ff       <= rsp_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_read_value     = rsp_ff.read_value;
   assign rsp_found_position = rsp_ff.found_position;
   assign rsp_status         = rsp_ff.status;
   assign rsp_entry_count    = rsp_ff.entry_count;

`ifndef NO_ASSERTIONS
   count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while sequencer still busy");

   count_steps_by_one: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff)) ||
                        (count_ff == $past(count_ff) + CNT_W'(1)) ||
                        (count_ff + CNT_W'(1) == $past(count_ff)))
      else $error("entry count changed by more than one");

   busy_gives_result: assert property (@(posedge clock) disable iff (reset)
      (busy && !$past(busy) && !$past(reset)) |-> !rsp_strobe)
      else $error("result strobe in first busy cycle");
`endif

endmodule
